FILE: src/cptr_pkg.sv
package cptr_pkg;

   localparam int MAX_PARTICLES  = 1024;
   localparam int MAX_REDUCTIONS = 8;

   localparam int ADDR_W  = $clog2(MAX_PARTICLES);
   localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
   localparam int K_W     = 5;
   localparam int POS_W   = 32;
   localparam int STEP_W  = 32;
   localparam int DIST_W  = 31;
   localparam int DIFF_W  = POS_W + 1;
   localparam int PROD_W  = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0]   BASE_STEP_RESET = 32'hFFFF_FFFF;
   localparam logic [DIST_W-1:0]   BASE_DIST_RESET = 31'd26844;

   // x / 10 == (x * RECIP_TEN) >> DIV_SHIFT for every 32-bit x
   localparam logic [STEP_W-1:0]   RECIP_TEN = 32'hCCCC_CCCD;
   localparam int                  DIV_SHIFT = 35;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_STEP     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_DISTANCE = 2'd1;

endpackage

FILE: src/cptr_ram.sv
module cptr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/close_pair_timestep_reducer_core.sv
// Channel   Ports                                              Handshake
// request   req_pos_x, req_pos_y, req_last_particle            start & !busy
// response  rsp_time_step, rsp_reductions, rsp_saturated       rsp_valid, one cycle
// config    csr_index, csr_wdata                               csr_we
//
// A request with particles already stored steps through ST_DIFF, ST_MX, ST_MY and
// ST_ACC per stored particle; one shared 32x32 multiplier squares dx, then dy.
// A last request adds ST_RSQ/ST_RCMP per check, ST_RDS/ST_RDD/ST_RDU per reduction.
// Reset is synchronous; the cloud starts empty and the registers return to defaults.
// The receiver cannot stall: rsp_valid is high for exactly one cycle per result.
module close_pair_timestep_reducer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [cptr_pkg::POS_W-1:0]        req_pos_x,
   input  logic [cptr_pkg::POS_W-1:0]        req_pos_y,
   input  logic                              req_last_particle,
   output logic                              rsp_valid,
   output logic [cptr_pkg::STEP_W-1:0]       rsp_time_step,
   output logic [cptr_pkg::K_W-1:0]          rsp_reductions,
   output logic                              rsp_saturated,
   input  logic                              csr_we,
   input  logic [cptr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cptr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIFF = 4'd1;
   localparam logic [3:0] ST_MX   = 4'd2;
   localparam logic [3:0] ST_MY   = 4'd3;
   localparam logic [3:0] ST_ACC  = 4'd4;
   localparam logic [3:0] ST_RSQ  = 4'd5;
   localparam logic [3:0] ST_RCMP = 4'd6;
   localparam logic [3:0] ST_RDS  = 4'd7;
   localparam logic [3:0] ST_RDD  = 4'd8;
   localparam logic [3:0] ST_RDU  = 4'd9;

   localparam int ADDR_W = cptr_pkg::ADDR_W;
   localparam int CNT_W  = cptr_pkg::CNT_W;
   localparam int POS_W  = cptr_pkg::POS_W;
   localparam int DIFF_W = cptr_pkg::DIFF_W;
   localparam int PROD_W = cptr_pkg::PROD_W;
   localparam int STEP_W = cptr_pkg::STEP_W;
   localparam int DIST_W = cptr_pkg::DIST_W;
   localparam int K_W    = cptr_pkg::K_W;
   localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(cptr_pkg::MAX_PARTICLES);
   localparam logic [K_W-1:0]    MAX_K   = K_W'(cptr_pkg::MAX_REDUCTIONS);
   localparam logic [PROD_W-1:0] ALL_ONES = '1;

   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [ADDR_W-1:0]   i_ff, i_in;
   logic [POS_W-1:0]    px_ff, px_in;
   logic [POS_W-1:0]    py_ff, py_in;
   logic                last_ff, last_in;
   logic [DIFF_W-1:0]   dx_ff, dx_in;
   logic [DIFF_W-1:0]   dy_ff, dy_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W-1:0]   sx_ff, sx_in;
   logic [PROD_W-1:0]   min_ff, min_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic                sat_ff, sat_in;
   logic                valid_ff, valid_in;
   logic [STEP_W-1:0]   base_step_ff;
   logic [DIST_W-1:0]   base_dist_ff;

   logic                accept;
   logic                ram_we;
   logic [2*POS_W-1:0]  ram_rdata;
   logic [POS_W-1:0]    mul_a;
   logic [POS_W-1:0]    mul_b;
   logic [DIFF_W-1:0]   diff_x;
   logic [DIFF_W-1:0]   diff_y;
   logic [PROD_W-1:0]   sy;
   logic [PROD_W:0]     sum;
   logic [PROD_W-1:0]   d2;
   logic                too_close;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign ram_we = accept && (count_ff < MAX_CNT);

   cptr_ram #(
      .WIDTH (2 * POS_W),
      .DEPTH (cptr_pkg::MAX_PARTICLES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata ({req_pos_x, req_pos_y}),
      .raddr (i_in),
      .rdata (ram_rdata)
   );

   assign diff_x = {px_ff[POS_W-1], px_ff} - {ram_rdata[2*POS_W-1], ram_rdata[2*POS_W-1:POS_W]};
   assign diff_y = {py_ff[POS_W-1], py_ff} - {ram_rdata[POS_W-1], ram_rdata[POS_W-1:0]};

   assign sy        = dy_ff[DIFF_W-1] ? ALL_ONES : prod_ff;
   assign sum       = {1'b0, sx_ff} + {1'b0, sy};
   assign d2        = sum[PROD_W] ? ALL_ONES : sum[PROD_W-1:0];
   assign too_close = (min_ff <= prod_ff);

   always_comb begin
      unique case (state_ff)
         ST_MX: begin
            mul_a = dx_ff[POS_W-1:0];
            mul_b = dx_ff[POS_W-1:0];
         end
         ST_MY: begin
            mul_a = dy_ff[POS_W-1:0];
            mul_b = dy_ff[POS_W-1:0];
         end
         ST_RSQ: begin
            mul_a = POS_W'(dist_ff);
            mul_b = POS_W'(dist_ff);
         end
         ST_RDS: begin
            mul_a = step_ff;
            mul_b = cptr_pkg::RECIP_TEN;
         end
         ST_RDD: begin
            mul_a = POS_W'(dist_ff);
            mul_b = cptr_pkg::RECIP_TEN;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      last_in  = last_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      prod_in  = mul_a * mul_b;
      sx_in    = sx_ff;
      min_in   = min_ff;
      step_in  = step_ff;
      dist_in  = dist_ff;
      k_in     = k_ff;
      sat_in   = sat_ff;
      valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               px_in   = req_pos_x;
               py_in   = req_pos_y;
               last_in = req_last_particle;
               n_in    = count_ff;
               i_in    = '0;
               step_in = base_step_ff;
               dist_in = base_dist_ff;
               k_in    = '0;
               if (count_ff < MAX_CNT) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (count_ff != '0) begin
                  state_in = ST_DIFF;
               end else if (req_last_particle) begin
                  state_in = ST_RSQ;
               end
            end
         end
         ST_DIFF: begin
            dx_in    = diff_x[DIFF_W-1] ? -diff_x : diff_x;
            dy_in    = diff_y[DIFF_W-1] ? -diff_y : diff_y;
            state_in = ST_MX;
         end
         ST_MX: begin
            state_in = ST_MY;
         end
         ST_MY: begin
            sx_in    = dx_ff[DIFF_W-1] ? ALL_ONES : prod_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (d2 < min_ff) begin
               min_in = d2;
            end
            if ({1'b0, i_ff} + CNT_W'(1) == n_ff) begin
               state_in = last_ff ? ST_RSQ : ST_IDLE;
            end else begin
               i_in     = i_ff + ADDR_W'(1);
               state_in = ST_DIFF;
            end
         end
         ST_RSQ: begin
            state_in = ST_RCMP;
         end
         ST_RCMP: begin
            if (too_close && (k_ff < MAX_K)) begin
               state_in = ST_RDS;
            end else begin
               sat_in   = too_close;
               valid_in = 1'b1;
               count_in = '0;
               min_in   = ALL_ONES;
               state_in = ST_IDLE;
            end
         end
         ST_RDS: begin
            state_in = ST_RDD;
         end
         ST_RDD: begin
            step_in  = STEP_W'(prod_ff[PROD_W-1:cptr_pkg::DIV_SHIFT]);
            state_in = ST_RDU;
         end
         ST_RDU: begin
            dist_in  = DIST_W'(prod_ff[PROD_W-1:cptr_pkg::DIV_SHIFT]);
            k_in     = k_ff + K_W'(1);
            state_in = ST_RSQ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         min_ff       <= ALL_ONES;
         valid_ff     <= 1'b0;
         base_step_ff <= cptr_pkg::BASE_STEP_RESET;
         base_dist_ff <= cptr_pkg::BASE_DIST_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         min_ff   <= min_in;
         valid_ff <= valid_in;
         if (csr_we) begin
            unique case (csr_index)
               cptr_pkg::REG_BASE_STEP:     base_step_ff <= csr_wdata;
               cptr_pkg::REG_BASE_DISTANCE: base_dist_ff <= csr_wdata[DIST_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      i_ff    <= i_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      prod_ff <= prod_in;
      sx_ff   <= sx_in;
      step_ff <= step_in;
      dist_ff <= dist_in;
      k_ff    <= k_in;
      sat_ff  <= sat_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_time_step  = step_ff;
   assign rsp_reductions = k_ff;
   assign rsp_saturated  = sat_ff;

endmodule

FILE: tb/sv/tb_close_pair_timestep_reducer_core.sv
`timescale 1ns / 100ps

module tb_close_pair_timestep_reducer_core;
   import cptr_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;
   localparam int STALL_LIMIT   = 20000;
   localparam int RANDOM_ITEMS  = 580;
   localparam int RANDOM_PHASES = 6;

   typedef struct {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic             last;
   } particle_type;

   typedef struct {
      logic [STEP_W-1:0] time_step;
      logic [K_W-1:0]    reductions;
      logic              saturated;
   } step_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [POS_W-1:0]      req_pos_x = '0;
   logic [POS_W-1:0]      req_pos_y = '0;
   logic                  req_last_particle = 1'b0;
   logic                  rsp_valid;
   logic [STEP_W-1:0]     rsp_time_step;
   logic [K_W-1:0]        rsp_reductions;
   logic                  rsp_saturated;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   particle_type    pending[$];
   step_result_type due_steps[$];

   logic [STEP_W-1:0] model_step;
   logic [DIST_W-1:0] model_dist;
   logic [POS_W-1:0]  cloud_x [MAX_PARTICLES];
   logic [POS_W-1:0]  cloud_y [MAX_PARTICLES];
   int                cloud_size;
   logic [PROD_W-1:0] closest_sq;

   int   failures = 0;
   int   idle_cycles = 0;
   int   queued = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   logic steady = 1'b0;
   logic req_fired = 1'b0;

   close_pair_timestep_reducer_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_last_particle (req_last_particle),
      .rsp_valid         (rsp_valid),
      .rsp_time_step     (rsp_time_step),
      .rsp_reductions    (rsp_reductions),
      .rsp_saturated     (rsp_saturated),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [PROD_W-1:0] sep_squared(logic [POS_W-1:0] xa, logic [POS_W-1:0] ya,
                                                     logic [POS_W-1:0] xb, logic [POS_W-1:0] yb);
      logic [DIFF_W-1:0]   dx;
      logic [DIFF_W-1:0]   dy;
      logic [PROD_W-1:0]   mx;
      logic [PROD_W-1:0]   my;
      logic [PROD_W:0]     sum;
      dx = {xa[POS_W-1], xa} - {xb[POS_W-1], xb};
      dy = {ya[POS_W-1], ya} - {yb[POS_W-1], yb};
      if (dx[DIFF_W-1]) dx = ~dx + 1'b1;
      if (dy[DIFF_W-1]) dy = ~dy + 1'b1;
      mx = dx[DIFF_W-1] ? '1 : PROD_W'(dx[POS_W-1:0]);
      my = dy[DIFF_W-1] ? '1 : PROD_W'(dy[POS_W-1:0]);
      if (!dx[DIFF_W-1]) mx = mx * mx;
      if (!dy[DIFF_W-1]) my = my * my;
      sum = {1'b0, mx} + {1'b0, my};
      return sum[PROD_W] ? '1 : sum[PROD_W-1:0];
   endfunction

   function automatic step_result_type reduce_step(logic [PROD_W-1:0] closest);
      step_result_type   r;
      logic [STEP_W-1:0] step;
      logic [PROD_W-1:0] thresh;
      int                k;
      logic              close;
      step = model_step;
      thresh = PROD_W'(model_dist);
      k = 0;
      close = closest <= thresh * thresh;
      while (close && k < MAX_REDUCTIONS) begin
         k++;
         thresh = thresh / 10;
         step = step / 10;
         close = closest <= thresh * thresh;
      end
      r.time_step  = step;
      r.reductions = K_W'(k);
      r.saturated  = close;
      return r;
   endfunction

   task automatic absorb_particle(input particle_type p);
      int                n;
      int                i;
      logic [PROD_W-1:0] d2;
      n = (cloud_size > MAX_PARTICLES) ? MAX_PARTICLES : cloud_size;
      for (i = 0; i < n; i++) begin
         d2 = sep_squared(p.x, p.y, cloud_x[i], cloud_y[i]);
         if (d2 < closest_sq) closest_sq = d2;
      end
      if (n < MAX_PARTICLES) begin
         cloud_x[n] = p.x;
         cloud_y[n] = p.y;
         cloud_size = n + 1;
      end
      if (p.last) begin
         due_steps.push_back(reduce_step(closest_sq));
         cloud_size = 0;
         closest_sq = '1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      failures++;
      $display("%0t ns: mismatch on %s, got %0h, expected %0h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      step_result_type want;
      particle_type    got;
      if (reset) begin
         model_step  = BASE_STEP_RESET;
         model_dist  = BASE_DIST_RESET;
         cloud_size  = 0;
         closest_sq  = '1;
         idle_cycles = 0;
         req_fired <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (due_steps.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_time_step), 64'(0));
            end else begin
               want = due_steps.pop_front();
               if (rsp_time_step !== want.time_step)
                  report_mismatch("time_step", 64'(rsp_time_step), 64'(want.time_step));
               if (rsp_reductions !== want.reductions)
                  report_mismatch("reductions", 64'(rsp_reductions), 64'(want.reductions));
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", 64'(rsp_saturated), 64'(want.saturated));
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_BASE_STEP:     model_step = csr_wdata;
               REG_BASE_DISTANCE: model_dist = csr_wdata[DIST_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            got.x    = req_pos_x;
            got.y    = req_pos_y;
            got.last = req_last_particle;
            absorb_particle(got);
         end
         req_fired <= start && !busy;
         if (rsp_valid || csr_we || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_close_pair_timestep_reducer_core NOT OK");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      particle_type p;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_fired) begin
         if (gap_left == 0 && pending.size() != 0) begin
            p = pending.pop_front();
            req_pos_x         <= p.x;
            req_pos_y         <= p.y;
            req_last_particle <= p.last;
            start             <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            end
         end else begin
            if (gap_left > 0) gap_left--;
            start             <= 1'b0;
            req_pos_x         <= $urandom();
            req_pos_y         <= $urandom();
            req_last_particle <= 1'($urandom_range(0, 1));
         end
      end
   end

   task automatic push_particle(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                input logic last);
      particle_type p;
      p.x    = x;
      p.y    = y;
      p.last = last;
      pending.push_back(p);
      queued++;
   endtask

   function automatic logic [POS_W-1:0] near(logic [POS_W-1:0] c, int s);
      logic [POS_W-1:0] off;
      off = $urandom() & ((32'd1 << s) - 1);
      return $urandom_range(0, 1) ? c + off : c - off;
   endfunction

   function automatic logic [POS_W-1:0] extreme_coord();
      case ($urandom_range(0, 4))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_cloud(input int n);
      int               mode;
      int               s;
      int               i;
      logic [POS_W-1:0] cx;
      logic [POS_W-1:0] cy;
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      mode = $urandom_range(0, 9);
      s    = $urandom_range(0, 31);
      cx   = $urandom();
      cy   = $urandom();
      px   = cx;
      py   = cy;
      for (i = 0; i < n; i++) begin
         case (mode)
            0, 1: begin
               px = $urandom();
               py = $urandom();
            end
            8: begin
               if (i == 0 || $urandom_range(0, 2) != 0) begin
                  px = near(cx, s);
                  py = near(cy, s);
               end
            end
            9: begin
               px = extreme_coord();
               py = extreme_coord();
            end
            default: begin
               px = near(cx, s);
               py = near(cy, s);
            end
         endcase
         push_particle(px, py, i == n - 1);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= $urandom();
   endtask

   task automatic drain();
      while (pending.size() != 0 || start) @(posedge clock);
      do @(negedge clock); while (due_steps.size() != 0 || busy);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      int phase;
      int i;
      int goal;
      logic [POS_W-1:0] fx;
      logic [POS_W-1:0] fy;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_particle(32'd0, 32'd0, 1'b1);
      push_particle(32'd5, 32'd7, 1'b0);
      push_particle(32'd5, 32'd7, 1'b1);
      push_particle(32'h8000_0000, 32'h8000_0000, 1'b0);
      push_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      push_particle(32'h8000_0000, 32'h0000_0000, 1'b0);
      push_particle(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
      push_particle(32'd0, 32'd0, 1'b0);
      push_particle(32'd26844, 32'd0, 1'b1);
      push_particle(32'd0, 32'd0, 1'b0);
      push_particle(32'd0, 32'd26845, 1'b1);
      push_particle(-32'sd100, -32'sd100, 1'b0);
      push_particle(32'd100000, 32'd5, 1'b0);
      push_particle(-32'sd100, -32'sd90, 1'b1);
      drain();

      // overfull cloud: the two extra particles are compared but never stored
      steady = 1'b1;
      for (i = 0; i < MAX_PARTICLES; i++) begin
         if (i == 3) begin
            fx = $urandom();
            fy = $urandom();
            push_particle(fx, fy, 1'b0);
         end else begin
            push_particle($urandom(), $urandom(), 1'b0);
         end
      end
      push_particle(fx + 1'b1, fy, 1'b0);
      push_particle(fx + 1'b1, fy, 1'b1);
      drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady = (phase == 4);
         case (phase)
            0: begin
               write_reg(REG_BASE_STEP, 32'h0000_0000);
               write_reg(REG_BASE_DISTANCE, 32'hFFFF_FFFF);
            end
            1: begin
               write_reg(REG_BASE_STEP, 32'hFFFF_FFFF);
               write_reg(REG_BASE_DISTANCE, 32'h0000_0000);
            end
            2: begin
               write_reg(REG_BASE_STEP, $urandom());
               write_reg(REG_BASE_DISTANCE, $urandom());
               write_reg(REG_SPARE_LO, $urandom());
            end
            3: begin
               write_reg(REG_BASE_STEP, $urandom_range(0, 99));
               write_reg(REG_BASE_DISTANCE, $urandom_range(1, 30000));
            end
            4: begin
               write_reg(REG_BASE_DISTANCE, $urandom_range(0, 32'h7FFF_FFFF));
               write_reg(REG_BASE_STEP, $urandom());
            end
            default: begin
               write_reg(REG_SPARE_HI, $urandom());
               write_reg(REG_BASE_STEP, $urandom());
               write_reg(REG_BASE_DISTANCE, $urandom_range(1000, 5000000));
            end
         endcase
         goal = queued + RANDOM_ITEMS / RANDOM_PHASES;
         while (queued < goal)
            queue_cloud(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 8));
         drain();
      end

      repeat (40) @(negedge clock);
      if (due_steps.size() != 0)
         report_mismatch("responses never arrived", 64'(0), 64'(due_steps.size()));
      if (failures == 0) begin
         $display("tb_close_pair_timestep_reducer_core OK");
      end else begin
         $display("tb_close_pair_timestep_reducer_core NOT OK");
      end
      $finish;
   end

endmodule
